// ===== src/rpse_pkg.sv =====
// ---------------------------------------------------------------------------
// rpse_pkg
// shared types and constants of the relocation patch stream engine
// ---------------------------------------------------------------------------
`default_nettype none
package rpse_pkg;
    localparam int NUM_SECTIONS_DEF = 32;

    localparam logic [1:0] OP_SECTION = 2'd0;
    localparam logic [1:0] OP_IMPORT  = 2'd1;
    localparam logic [1:0] OP_RELOC   = 2'd2;

    localparam logic [2:0] ST_APPLIED  = 3'd0;
    localparam logic [2:0] ST_SKIPPED  = 3'd1;
    localparam logic [2:0] ST_SECTION  = 3'd2;
    localparam logic [2:0] ST_END      = 3'd3;
    localparam logic [2:0] ST_MISSING  = 3'd4;
    localparam logic [2:0] ST_ACCEPTED = 3'd5;

    localparam logic [31:0] MASK_W24 = 32'h03FF_FFFC;
    localparam logic [31:0] MASK_W14 = 32'h0000_FFFC;
    localparam logic [31:0] HA_CARRY = 32'h0000_8000;
    localparam logic [7:0]  TYPE_NOP = 8'd201;
    localparam logic [7:0]  TYPE_SET = 8'd202;
    localparam logic [7:0]  TYPE_END = 8'd203;

    localparam logic [3:0] REG_MODULE_ID = 4'd0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOKUP,
        S_DECIDE,
        S_SCAN,
        S_SCAN_WAIT,
        S_DONE,
        S_OUT
    } state_t;
endpackage
`default_nettype wire

// ===== src/relocation_patch_stream_engine_core.sv =====
// ---------------------------------------------------------------------------
// relocation_patch_stream_engine_core
// applies relocation entries and emits masked big-endian patch writes
// ---------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  s_axis  | in        | tvalid/tready           | tdata: entry fields
//  m_axis  | out       | tvalid/tready           | tdata: write and status fields
//  apb     | in        | psel/penable/pwrite     | module_id at address 0
//
// a relocation entry needing a containment check walks the section table one
// entry per cycle through one compare unit; other relocation entries and
// section and import entries take no scan. the section memory has one read
// port, so the scan is serial. reset clears the control state and the section
// presence bits.
// no new transaction is taken until the result is taken.
`default_nettype none
module relocation_patch_stream_engine_core
    import rpse_pkg::*;
#(
    parameter int NUM_SECTIONS = NUM_SECTIONS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // opcode[1:0], section_index[9:2], section_address[41:10],
    // section_length[73:42], import_id[105:74], offset_delta[121:106],
    // reloc_type[129:122], addend[161:130], zeros
    input  wire logic [167:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // write_valid[0], write_address[32:1], write_data[64:33],
    // write_mask[96:65], write_halfword[97], status[100:98],
    // applied_total[132:101], skipped_total[164:133], zeros
    output logic [167:0]      m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int IW = (NUM_SECTIONS > 1) ? $clog2(NUM_SECTIONS) : 1;
    localparam int CW = $clog2(NUM_SECTIONS + 1);

    // input fields
    logic [1:0]  opcode;
    logic [7:0]  section_index;
    logic [31:0] section_address, section_length, import_id, addend;
    logic [15:0] offset_delta;
    logic [7:0]  reloc_type;
    assign opcode          = s_axis_tdata[1:0];
    assign section_index   = s_axis_tdata[9:2];
    assign section_address = s_axis_tdata[41:10];
    assign section_length  = s_axis_tdata[73:42];
    assign import_id       = s_axis_tdata[105:74];
    assign offset_delta    = s_axis_tdata[121:106];
    assign reloc_type      = s_axis_tdata[129:122];
    assign addend          = s_axis_tdata[161:130];

    // section memories and presence bits
    logic [31:0] base_mem [NUM_SECTIONS];
    logic [31:0] len_mem  [NUM_SECTIONS];
    logic [NUM_SECTIONS-1:0] present_reg;
    logic [31:0] rd_base_reg, rd_len_reg;
    logic        rd_pres_reg;

    state_t state_reg, state_next;
    logic [31:0] module_id_reg, patch_reg, import_reg, applied_reg, skipped_reg;
    logic [7:0]  idx_reg, type_reg;
    logic [31:0] addend_reg;
    logic [CW-1:0] scan_reg;
    logic        idx_ok_reg;
    logic [31:0] wdata_reg, wmask_reg;
    logic        half_reg;
    logic [167:0] out_reg;

    // read address: entry index while taking and looking up, next scan entry
    // during the scan so the read data lines up with scan_reg
    logic [IW-1:0] rd_addr;
    logic          rd_en;
    logic          s_take;
    logic          sec_in_range;
    assign s_take = s_axis_tvalid && s_axis_tready;
    assign sec_in_range = 9'(section_index) < 9'(NUM_SECTIONS);

    always_comb
    begin
        if (state_reg == S_SCAN)
            rd_addr = '0;
        else if (state_reg == S_SCAN_WAIT)
            rd_addr = (scan_reg == CW'(NUM_SECTIONS - 1)) ? scan_reg[IW-1:0]
                                                          : IW'(scan_reg + CW'(1));
        else if (state_reg == S_IDLE)
            rd_addr = IW'(section_index);
        else
            rd_addr = idx_reg[IW-1:0];
        rd_en = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s_take && opcode == OP_SECTION && sec_in_range)
        begin
            base_mem[IW'(section_index)] <= section_address;
            len_mem[IW'(section_index)]  <= section_length;
        end
        if (rd_en)
        begin
            rd_base_reg <= base_mem[rd_addr];
            rd_len_reg  <= len_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            rd_pres_reg <= 1'b0;
        end
        else
        begin
            rd_pres_reg <= present_reg[rd_addr];
            if (s_take && opcode == OP_SECTION && sec_in_range)
                present_reg[IW'(section_index)] <= (section_length != 32'd0);
        end
    end

    // apb
    assign pready = 1'b1;
    assign prdata = (paddr == 2'(REG_MODULE_ID)) ? module_id_reg : 32'd0;

    // target and value computation from lookup data
    logic        tgt_present, supported, tgt_missing;
    logic [31:0] target, absv, relv;
    logic [31:0] cdata, cmask;
    logic        ctype_ok, chalf, csize0;
    always_comb
    begin
        tgt_present = idx_ok_reg && rd_pres_reg && (rd_len_reg != 32'd0);
        target      = (import_reg == 32'd0 || !tgt_present) ? 32'd0 : rd_base_reg;
        supported   = (import_reg == 32'd0) || (import_reg == module_id_reg);
        tgt_missing = (import_reg != 32'd0) && (target == 32'd0);
        absv        = target + addend_reg;
        relv        = absv - patch_reg;
        cdata = 32'd0;
        cmask = 32'd0;
        ctype_ok = 1'b1;
        chalf = 1'b0;
        csize0 = 1'b0;
        case (type_reg) inside
            8'd0, TYPE_NOP: csize0 = 1'b1;
            8'd1:  begin cdata = absv; cmask = 32'hFFFF_FFFF; end
            8'd2:  begin cdata = absv & MASK_W24; cmask = MASK_W24; end
            8'd10: begin cdata = relv & MASK_W24; cmask = MASK_W24; end
            8'd7, 8'd8, 8'd9:
                   begin cdata = absv & MASK_W14; cmask = MASK_W14; end
            8'd11, 8'd12, 8'd13:
                   begin cdata = relv & MASK_W14; cmask = MASK_W14; end
            8'd3, 8'd4:
                   begin chalf = 1'b1; cdata = {16'd0, absv[15:0]}; end
            8'd5:  begin chalf = 1'b1; cdata = {16'd0, absv[31:16]}; end
            8'd6:  begin
                       chalf = 1'b1;
                       cdata = {16'd0, absv[31:16] + 16'((absv & HA_CARRY) != 0)};
                   end
            default: ctype_ok = 1'b0;
        endcase
    end

    // shared compare unit: one section entry per cycle
    logic [31:0] off, room;
    logic        hit, fits_now;
    always_comb
    begin
        off  = patch_reg - rd_base_reg;
        room = rd_len_reg - off;
        hit  = rd_pres_reg && (rd_len_reg != 32'd0) && (patch_reg >= rd_base_reg)
               && (off < rd_len_reg);
        fits_now = half_reg ? (room >= 32'd2) : (room >= 32'd4);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (s_take)
                    state_next = (opcode == OP_RELOC) ? S_LOOKUP : S_OUT;
            S_LOOKUP:    state_next = S_DECIDE;
            S_DECIDE:    state_next = S_DONE;
            S_SCAN:      state_next = S_SCAN_WAIT;
            S_SCAN_WAIT:
                if (hit || scan_reg == CW'(NUM_SECTIONS - 1))
                    state_next = S_DONE;
                else
                    state_next = S_SCAN_WAIT;
            S_DONE:      state_next = S_OUT;
            S_OUT:
                if (m_axis_tready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
        if (state_reg == S_DECIDE && type_reg != TYPE_END && type_reg != TYPE_SET
            && supported && !tgt_missing && ctype_ok && !csize0)
            state_next = S_SCAN;
    end

    // outputs
    always_comb
    begin
        s_axis_tready = (state_reg == S_IDLE);
        m_axis_tvalid = (state_reg == S_OUT);
        m_axis_tdata  = out_reg;
    end

    logic [2:0] status_reg;
    logic       emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            module_id_reg <= 32'd0;
            patch_reg     <= 32'd0;
            import_reg    <= 32'd0;
            applied_reg   <= 32'd0;
            skipped_reg   <= 32'd0;
            scan_reg      <= '0;
            status_reg    <= ST_ACCEPTED;
            emit_reg      <= 1'b0;
            out_reg       <= '0;
            idx_reg       <= 8'd0;
            idx_ok_reg    <= 1'b0;
            type_reg      <= 8'd0;
            addend_reg    <= 32'd0;
            wdata_reg     <= 32'd0;
            wmask_reg     <= 32'd0;
            half_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (psel && penable && pwrite && paddr == 2'(REG_MODULE_ID))
                module_id_reg <= pwdata;
            unique case (state_reg)
                S_IDLE:
                    if (s_take)
                    begin
                        idx_reg    <= section_index;
                        idx_ok_reg <= sec_in_range;
                        type_reg   <= reloc_type;
                        addend_reg <= addend;
                        emit_reg   <= 1'b0;
                        status_reg <= ST_ACCEPTED;
                        if (opcode == OP_IMPORT)
                        begin
                            import_reg <= import_id;
                            patch_reg  <= 32'd0;
                        end
                        else if (opcode == OP_RELOC)
                            patch_reg <= patch_reg + 32'(offset_delta);
                        if (opcode != OP_RELOC)
                            out_reg <= {3'd0, skipped_reg, applied_reg, ST_ACCEPTED,
                                        1'b0, 96'd0, 1'b0};
                    end
                S_DECIDE:
                begin
                    wdata_reg <= cdata;
                    wmask_reg <= chalf ? 32'h0000_FFFF : cmask;
                    half_reg  <= chalf;
                    scan_reg  <= '0;
                    if (type_reg == TYPE_END)
                        status_reg <= ST_END;
                    else if (type_reg == TYPE_SET)
                    begin
                        patch_reg  <= tgt_present ? rd_base_reg : 32'd0;
                        status_reg <= (tgt_present && rd_base_reg != 32'd0) ?
                                      ST_SECTION : ST_MISSING;
                    end
                    else if (!supported || tgt_missing || !ctype_ok)
                    begin
                        status_reg  <= ST_SKIPPED;
                        skipped_reg <= skipped_reg + 32'd1;
                    end
                    else if (csize0)
                    begin
                        status_reg  <= ST_APPLIED;
                        applied_reg <= applied_reg + 32'd1;
                    end
                end
                S_SCAN: ;
                S_SCAN_WAIT:
                    if (hit || scan_reg == CW'(NUM_SECTIONS - 1))
                    begin
                        if (hit && fits_now)
                        begin
                            emit_reg    <= 1'b1;
                            status_reg  <= ST_APPLIED;
                            applied_reg <= applied_reg + 32'd1;
                        end
                        else
                        begin
                            status_reg  <= ST_SKIPPED;
                            skipped_reg <= skipped_reg + 32'd1;
                        end
                    end
                    else
                        scan_reg <= scan_reg + CW'(1);
                S_DONE:
                    out_reg <= {3'd0, skipped_reg, applied_reg, status_reg,
                                emit_reg & half_reg,
                                emit_reg ? wmask_reg : 32'd0,
                                emit_reg ? wdata_reg : 32'd0,
                                emit_reg ? patch_reg : 32'd0, emit_reg};
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input ready while result pending");
    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        !((applied_reg != $past(applied_reg)) && (skipped_reg != $past(skipped_reg))))
        else $error("both counters moved");
    a_emit_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> m_axis_tdata[96:65] != 32'd0)
        else $error("write with empty mask");
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the relocation patch stream engine: a queue-fed
// driver, a monitor that checks every result against a built-in predictor,
// apb writes of module_id between phases, random idling on both sides
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    import rpse_pkg::*;

    localparam int NSEC = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] addend;
        logic [7:0]  rtype;
        logic [15:0] delta;
        logic [31:0] imp;
        logic [31:0] slen;
        logic [31:0] saddr;
        logic [7:0]  sidx;
        logic [1:0]  op;
    } entry_t;

    typedef struct packed {
        logic [31:0] skipped;
        logic [31:0] applied;
        logic [2:0]  status;
        logic        half;
        logic [31:0] wmask;
        logic [31:0] wdata;
        logic [31:0] waddr;
        logic        wvalid;
    } patch_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [167:0] s_axis_tdata;     // op, sidx, saddr, slen, import, delta, type, addend
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [167:0] m_axis_tdata;     // wvalid, waddr, wdata, wmask, half, status, applied, skipped
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [1:0]   paddr;
    logic [31:0]  pwdata;
    logic [31:0]  prdata;
    logic         pready;

    relocation_patch_stream_engine_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state mirrors the block
    logic [31:0] mdl_module;
    logic [31:0] mdl_base [NSEC];
    logic [31:0] mdl_len  [NSEC];
    logic [31:0] mdl_ptr, mdl_import, mdl_applied, mdl_skipped;

    entry_t entry_q[$];
    patch_t expected_q[$];
    int     mismatches;
    int     cycles;
    bit     stall_long;      // receiver hold-off request
    bit     feeding;         // driver allowed to send

    // which sections the stimulus has loaded with nonzero length
    bit     loaded [NSEC];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [31:0] section_target(logic [7:0] idx);
        if (idx >= NSEC || mdl_len[idx] == 0)
            return 32'd0;
        return mdl_base[idx];
    endfunction

    // size bytes at addr lie inside the first present section holding addr
    function automatic bit patch_fits(logic [31:0] addr, logic [31:0] size);
        logic [31:0] off;
        for (int i = 0; i < NSEC; i++)
        begin
            if (mdl_len[i] != 0 && addr >= mdl_base[i])
            begin
                off = addr - mdl_base[i];
                if (off < mdl_len[i])
                    return (mdl_len[i] - off) >= size;
            end
        end
        return 1'b0;
    endfunction

    function automatic patch_t predict_patch(entry_t e);
        patch_t r;
        logic [31:0] target, absv, relv, size;
        bit ok, supported;
        r = '0;
        r.status = ST_ACCEPTED;
        if (e.op == OP_SECTION)
        begin
            if (e.sidx < NSEC)
            begin
                mdl_base[e.sidx] = e.saddr;
                mdl_len[e.sidx] = e.slen;
            end
        end
        else if (e.op == OP_IMPORT)
        begin
            mdl_import = e.imp;
            mdl_ptr = 32'd0;
        end
        else if (e.op == OP_RELOC)
        begin
            mdl_ptr = mdl_ptr + e.delta;
            if (e.rtype == TYPE_END)
                r.status = ST_END;
            else if (e.rtype == TYPE_SET)
            begin
                mdl_ptr = section_target(e.sidx);
                r.status = (mdl_ptr == 0) ? ST_MISSING : ST_SECTION;
            end
            else
            begin
                ok = 1'b0;
                supported = (mdl_import == 0) || (mdl_import == mdl_module);
                target = (mdl_import == 0) ? 32'd0 : section_target(e.sidx);
                if (supported && !(mdl_import != 0 && target == 0))
                begin
                    absv = target + e.addend;
                    relv = absv - mdl_ptr;
                    size = 4;
                    ok = 1'b1;
                    case (e.rtype) inside
                        8'd0, TYPE_NOP: size = 0;
                        8'd1: begin r.wdata = absv; r.wmask = '1; end
                        8'd2: begin r.wdata = absv & MASK_W24; r.wmask = MASK_W24; end
                        8'd10: begin r.wdata = relv & MASK_W24; r.wmask = MASK_W24; end
                        8'd7, 8'd8, 8'd9:
                        begin
                            r.wdata = absv & MASK_W14;
                            r.wmask = MASK_W14;
                        end
                        8'd11, 8'd12, 8'd13:
                        begin
                            r.wdata = relv & MASK_W14;
                            r.wmask = MASK_W14;
                        end
                        8'd3, 8'd4: begin size = 2; r.wdata = absv & 32'hFFFF; end
                        8'd5: begin size = 2; r.wdata = absv >> 16; end
                        8'd6:
                        begin
                            size = 2;
                            // high-adjusted: carry from bit 15 of the value
                            r.wdata = ((absv >> 16) + ((absv & HA_CARRY) != 0)) & 32'hFFFF;
                        end
                        default: begin ok = 1'b0; size = 0; end
                    endcase
                    if (ok && size != 0)
                    begin
                        if (patch_fits(mdl_ptr, size))
                        begin
                            r.wvalid = 1'b1;
                            r.waddr = mdl_ptr;
                            if (size == 2)
                            begin
                                r.half = 1'b1;
                                r.wmask = 32'hFFFF;
                            end
                        end
                        else
                            ok = 1'b0;
                    end
                    if (!r.wvalid)
                    begin
                        r.wdata = '0;
                        r.wmask = '0;
                        r.half = 1'b0;
                    end
                end
                if (ok)
                begin
                    mdl_applied = mdl_applied + 1;
                    r.status = ST_APPLIED;
                end
                else
                begin
                    mdl_skipped = mdl_skipped + 1;
                    r.status = ST_SKIPPED;
                end
            end
        end
        r.applied = mdl_applied;
        r.skipped = mdl_skipped;
        return r;
    endfunction

    // driver: random gap between transactions, valid held until taken
    int send_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= '0;
            send_gap <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_q.push_back(predict_patch(entry_t'(s_axis_tdata[161:0])));
                void'(entry_q.pop_front());
            end
            if (s_axis_tvalid && !s_axis_tready)
                ;
            else if (send_gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (feeding && entry_q.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                     && entry_q.size() != 0)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {6'd0, entry_q[0]};
                send_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor and receiver stalls
    int recv_gap;
    always @(posedge clk or negedge rst_n)
    begin
        patch_t got, want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_gap <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = patch_t'(m_axis_tdata[164:0]);
                if (expected_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected v%0d a%h d%h m%h h%0d s%0d %0d/%0d, got v%0d a%h d%h m%h h%0d s%0d %0d/%0d",
                                want.wvalid, want.waddr, want.wdata, want.wmask, want.half,
                                want.status, want.applied, want.skipped,
                                got.wvalid, got.waddr, got.wdata, got.wmask, got.half,
                                got.status, got.applied, got.skipped);
                    end
                end
            end
            if (stall_long)
                m_axis_tready <= 1'b0;
            else if (recv_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (m_axis_tvalid && m_axis_tready)
            begin
                recv_gap <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 10);
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // cycle limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** relocation_patch_stream_engine_core: FAILED **");
            $finish;
        end
    end

    task automatic apb_write(logic [1:0] addr, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= addr; pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mdl_module = value;
    endtask

    task automatic wait_drained();
        while (entry_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    function automatic entry_t blank_entry();
        entry_t e;
        e = '0;
        e.sidx = $urandom;
        e.saddr = $urandom;
        e.slen = $urandom;
        e.imp = $urandom;
        e.addend = $urandom;
        return e;
    endfunction

    task automatic push_section(logic [7:0] idx, logic [31:0] base, logic [31:0] len);
        entry_t e;
        e = blank_entry();
        e.op = OP_SECTION; e.sidx = idx; e.saddr = base; e.slen = len;
        if (idx < NSEC && len != 0)
            loaded[idx] = 1'b1;
        entry_q.push_back(e);
    endtask

    task automatic push_import(logic [31:0] imp);
        entry_t e;
        e = blank_entry();
        e.op = OP_IMPORT; e.imp = imp;
        entry_q.push_back(e);
    endtask

    task automatic push_reloc(logic [7:0] rtype, logic [7:0] idx, logic [15:0] delta,
                              logic [31:0] addend);
        entry_t e;
        e = blank_entry();
        e.op = OP_RELOC; e.rtype = rtype; e.sidx = idx; e.delta = delta; e.addend = addend;
        entry_q.push_back(e);
    endtask

    // a section index that has been given a nonzero length, so bases read are written
    function automatic logic [7:0] known_section();
        logic [7:0] idx;
        for (int k = 0; k < 40; k++)
        begin
            idx = $urandom_range(0, NSEC - 1);
            if (loaded[idx])
                return idx;
        end
        return 8'd0;
    endfunction

    function automatic logic [7:0] random_type();
        case ($urandom_range(0, 9))
            0: return TYPE_SET;
            1: return TYPE_END;
            2: return TYPE_NOP;
            3: return $urandom_range(14, 255);
            default: return $urandom_range(0, 13);
        endcase
    endfunction

    // one well-formed list: an optional section, import start, set-section, patches, end
    task automatic push_list(logic [31:0] imp);
        logic [7:0] idx;
        if ($urandom_range(0, 2) == 0)
            push_section($urandom_range(0, NSEC - 1),
                         $urandom_range(1, 32'h7FFF_0000) & ~32'h3, $urandom_range(4, 4096));
        push_import(imp);
        idx = known_section();
        push_reloc(TYPE_SET, idx, $urandom, $urandom);
        for (int k = 0; k < $urandom_range(2, 8); k++)
            push_reloc(random_type() == TYPE_SET ? 8'd1 : random_type(), known_section(),
                       $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 64),
                       $urandom);
        push_reloc(TYPE_END, $urandom, $urandom_range(0, 8), $urandom);
    endtask

    initial
    begin
        entry_t e;
        clk = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        stall_long = 1'b0; feeding = 1'b1;
        mismatches = 0; cycles = 0;
        mdl_module = 0; mdl_ptr = 0; mdl_import = 0; mdl_applied = 0; mdl_skipped = 0;
        for (int i = 0; i < NSEC; i++)
        begin
            mdl_base[i] = 0; mdl_len[i] = 0; loaded[i] = 0;
        end
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        apb_write(REG_MODULE_ID, 32'hFFFF_FFFF);

        // directed: table edges, every type, missing/absent cases
        push_reloc(TYPE_SET, 8'd3, 16'hFFFF, 32'h0);        // missing section
        push_section(8'd0, 32'h0000_1000, 32'h0000_0100);
        push_section(8'd1, 32'hFFFF_FF00, 32'h0000_0100);
        push_section(8'd31, 32'h0000_0000, 32'h0000_0010); // base zero
        push_section(8'd255, 32'h1234_5678, 32'hFFFF_FFFF); // ignored index
        push_section(8'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_section(8'd2, 32'h0000_2000, 32'h0000_0000);   // absent again
        push_reloc(TYPE_SET, 8'd31, 16'h0, 32'h0);          // base zero is missing
        push_reloc(TYPE_SET, 8'd0, 16'h0, 32'h0);
        for (int t = 0; t <= 13; t++)
            push_reloc(t, 8'd1, (t == 0) ? 16'h0 : 16'h4, 32'hFFFF_8000 + t);
        push_reloc(TYPE_NOP, 8'd0, 16'h00E0, 32'h0);
        push_reloc(8'd1, 8'd0, 16'h0, 32'h0);               // outside every section: skip
        push_reloc(8'd3, 8'd0, 16'h0, 32'h0);               // halfword outside every section
        push_reloc(8'd200, 8'd0, 16'h0, 32'h0);             // unknown type
        push_import(32'hFFFF_FFFF);
        push_reloc(8'd1, 8'd2, 16'h0, 32'h0);               // import target absent
        push_reloc(8'd1, 8'd200, 16'h0, 32'h0);             // index beyond table
        push_reloc(TYPE_END, 8'd0, 16'hFFFF, 32'h0);
        wait_drained();

        apb_write(REG_MODULE_ID, 32'h0000_0000);
        // receiver holds off while the sender keeps offering
        for (int k = 0; k < 4; k++)
            push_list($urandom_range(0, 1) ? 32'h0 : $urandom);
        stall_long = 1'b1;
        repeat (300) @(posedge clk);
        stall_long = 1'b0;
        wait_drained();

        for (int phase = 0; phase < 4; phase++)
        begin
            apb_write(REG_MODULE_ID, phase == 3 ? 32'hFFFF_FFFF : $urandom);
            while (entry_q.size() < 170)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    e = blank_entry();
                    e.op = $urandom_range(0, 3);
                    e.delta = $urandom;
                    e.rtype = $urandom;
                    if (e.op == OP_SECTION && e.sidx < NSEC && e.slen != 0)
                        loaded[e.sidx] = 1'b1;
                    if (e.op == OP_RELOC)
                        e.sidx = known_section();
                    entry_q.push_back(e);
                end
                else
                    push_list($urandom_range(0, 2) == 0 ? 32'h0 :
                              ($urandom_range(0, 3) == 0 ? $urandom : mdl_module));
            end
            // sender pause midway until everything is back
            while (entry_q.size() >= 85)
                @(posedge clk);
            feeding = 1'b0;
            while (expected_q.size() != 0 || s_axis_tvalid)
                @(posedge clk);
            feeding = 1'b1;
            wait_drained();
        end

        if (mismatches == 0 && expected_q.size() == 0)
            $display("** relocation_patch_stream_engine_core: PASSED **");
        else
            $display("** relocation_patch_stream_engine_core: FAILED **");
        $finish;
    end
endmodule
